>>> hw/rtl/dvrt_pkg.sv
// Shared types and constants for the distance-vector route table.
package dvrt_pkg;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 136;
    localparam int USER_W     = 2;
    localparam int HOPS_W     = 8;
    localparam logic [HOPS_W-1:0] MAX_HOPS_RST = 8'd16;

    typedef enum logic [1:0] {
        OP_UPDATE   = 2'd0,
        OP_WITHDRAW = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_NONE     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_HOP_HIGH = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_ROUTE = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0]        lookup_ip;
        logic [7:0]         route_hop;
        logic [47:0]        route_mac;
        logic signed [7:0]  route_device;
        logic [31:0]        route_mask;
        logic [31:0]        route_dest;
    } t_in_data;

    typedef struct packed {
        logic [6:0]         pad;
        logic [7:0]         found_hop;
        logic [47:0]        found_mac;
        logic signed [7:0]  found_device;
        logic [31:0]        found_mask;
        logic [31:0]        found_dest;
        logic               route_found;
    } t_out_data;

    typedef struct packed {
        logic               valid;
        logic [7:0]         hop;
        logic [47:0]        mac;
        logic signed [7:0]  device;
        logic [31:0]        mask;
        logic [31:0]        dest;
    } t_slot;

    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hw/rtl/dvrt_ctrl.sv
// Controller state machine sequencing clear, scan and commit of the route table.
module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_WAIT   = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

>>> hw/rtl/dvrt_datapath.sv
// Route table memory, slot scan, match accumulators and result register.
module dvrt_datapath
    import dvrt_pkg::*;
#(
    parameter  int TABLE_DEPTH = 64,
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_wr_en,
    input  logic [HOPS_W-1:0]     i_cfg_wr_data,
    input  logic [IN_DATA_W-1:0]  i_in_tdata,
    input  logic [USER_W-1:0]     i_in_tuser,
    output logic                  o_out_tvalid,
    input  logic                  i_out_tready,
    output logic [OUT_DATA_W-1:0] o_out_tdata,
    output logic [USER_W-1:0]     o_out_tuser
);

    t_slot r_mem [TABLE_DEPTH];

    logic [HOPS_W-1:0] r_max_hops;
    t_in_data          w_in;
    t_opcode           r_op;
    t_in_data          r_req;
    logic              r_hop_over;

    logic [IDX_W-1:0]  r_idx;
    logic              r_eval_vld;
    logic [IDX_W-1:0]  r_eval_idx;
    t_slot             r_rd_data;

    logic              r_dup_hit;
    logic              r_dup_better;
    logic [IDX_W-1:0]  r_dup_idx;
    logic              r_free_hit;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_best_hit;
    t_slot             r_best;

    logic              r_out_vld;
    t_out_data         r_out_data;
    t_status           r_out_status;

    logic              w_idx_last;
    logic              w_dup_match;
    logic              w_lk_match;
    logic              w_wd_match;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_slot             w_wdata;
    t_slot             w_new_slot;
    t_out_data         w_res_data;
    t_status           w_res_status;

    assign w_in       = t_in_data'(i_in_tdata);
    assign w_idx_last = (r_idx == IDX_W'(TABLE_DEPTH - 1));

    assign o_sts.idx_last = w_idx_last;
    assign o_sts.out_free = !r_out_vld || i_out_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hops <= MAX_HOPS_RST;
        end else if (i_cfg_wr_en) begin
            r_max_hops <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_opcode'(i_in_tuser);
            r_req      <= w_in;
            r_hop_over <= (w_in.route_hop > r_max_hops);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_eval_vld <= 1'b0;
        end else begin
            r_eval_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.clr || i_cmd.scan) begin
                r_idx <= w_idx_last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign w_dup_match = r_rd_data.valid && (r_rd_data.dest == r_req.route_dest)
                         && (r_rd_data.mask == r_req.route_mask);
    assign w_lk_match  = r_rd_data.valid
                         && (r_rd_data.dest == (r_req.lookup_ip & r_rd_data.mask));
    assign w_wd_match  = r_rd_data.valid && (r_rd_data.device == r_req.route_device);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_dup_hit  <= 1'b0;
            r_free_hit <= 1'b0;
            r_best_hit <= 1'b0;
        end else if (r_eval_vld) begin
            case (r_op)
                OP_UPDATE: begin
                    if (w_dup_match) begin
                        r_dup_hit    <= 1'b1;
                        r_dup_idx    <= r_eval_idx;
                        r_dup_better <= (r_rd_data.hop > r_req.route_hop);
                    end
                    if (!r_rd_data.valid && !r_free_hit) begin
                        r_free_hit <= 1'b1;
                        r_free_idx <= r_eval_idx;
                    end
                end
                OP_LOOKUP: begin
                    if (w_lk_match && (!r_best_hit || (r_rd_data.mask > r_best.mask))) begin
                        r_best_hit <= 1'b1;
                        r_best     <= r_rd_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_new_slot        = '0;
        w_new_slot.valid  = 1'b1;
        w_new_slot.hop    = r_req.route_hop;
        w_new_slot.mac    = r_req.route_mac;
        w_new_slot.device = r_req.route_device;
        w_new_slot.mask   = r_req.route_mask;
        w_new_slot.dest   = r_req.route_dest;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        if (i_cmd.clr) begin
            w_we = 1'b1;
        end else if (r_eval_vld && (r_op == OP_WITHDRAW) && w_wd_match) begin
            w_we          = 1'b1;
            w_waddr       = r_eval_idx;
            w_wdata       = r_rd_data;
            w_wdata.valid = 1'b0;
        end else if (i_cmd.commit && (r_op == OP_UPDATE) && !r_hop_over) begin
            w_wdata = w_new_slot;
            if (r_dup_hit) begin
                w_we    = r_dup_better;
                w_waddr = r_dup_idx;
            end else begin
                w_we    = r_free_hit;
                w_waddr = r_free_idx;
            end
        end
    end

    always_comb begin
        w_res_data   = '0;
        w_res_status = ST_DONE;
        case (r_op)
            OP_UPDATE: begin
                if (r_hop_over) begin
                    w_res_status = ST_HOP_HIGH;
                end else if (!r_dup_hit && !r_free_hit) begin
                    w_res_status = ST_FULL;
                end
            end
            OP_LOOKUP: begin
                if (r_best_hit) begin
                    w_res_data.route_found  = 1'b1;
                    w_res_data.found_dest   = r_best.dest;
                    w_res_data.found_mask   = r_best.mask;
                    w_res_data.found_device = r_best.device;
                    w_res_data.found_mac    = r_best.mac;
                    w_res_data.found_hop    = r_best.hop;
                end else begin
                    w_res_status = ST_NO_ROUTE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data   <= w_res_data;
            r_out_status <= w_res_status;
        end
    end

    assign o_out_tvalid = r_out_vld;
    assign o_out_tdata  = OUT_DATA_W'(r_out_data);
    assign o_out_tuser  = USER_W'(r_out_status);

endmodule

>>> hw/rtl/distance_vector_route_table_core.sv
// Top level of the distance-vector route table.
//
// Input stream (s_axis): one operation per transaction; tuser carries the
// opcode (update, withdraw, lookup), tdata the route and lookup fields.
// Output stream (m_axis): one result per operation; tuser carries the
// status, tdata the lookup match.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into max_hops at once.
//
// Every operation reads the table through its single read port, one slot a
// cycle, scanning every slot before its result is registered; a new
// operation is accepted only after the previous result has been committed.
// After reset the block runs a clearing pass over every slot, with
// s_axis_tready low, before the first transaction is accepted.
// A result waits in the output register while the receiver stalls; the next
// operation is still accepted and scanned, then held until that register
// frees up.
module distance_vector_route_table_core
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // route_dest, route_mask, route_device, route_mac, route_hop, lookup_ip
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [USER_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // route_found, found_dest, found_mask, found_device, found_mac, found_hop
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [USER_W-1:0]     m_axis_tuser,
    input  logic                  i_cfg_wr_en,
    input  logic [HOPS_W-1:0]     i_cfg_wr_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dvrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    dvrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .o_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .o_out_tdata   (m_axis_tdata),
        .o_out_tuser   (m_axis_tuser)
    );

endmodule

>>> hw/rtl/dvrt_checker.sv
// Port-level checks on the route table core, bound to the top level.
module dvrt_checker
    import dvrt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [USER_W-1:0]     m_axis_tuser
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("ports active after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while one is in flight");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == ST_DONE)
        else $error("match reported with a failing status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == '0)
        else $error("found fields not cleared without a match");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result dropped or changed");

endmodule

bind distance_vector_route_table_core dvrt_checker u_dvrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
